// ===== rtl/core/psa_pkg.sv =====
// Shared types and constants for the page slot allocator.
package psa_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int SLOT_W         = 8;
  localparam int ID_W           = 32;
  localparam int CFG_W          = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // command codes
  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   asset_id;
    logic [ID_W-1:0]   page_id;
    logic [ID_W-1:0]   frame_number;
    logic [SLOT_W-1:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [ID_W-1:0]   evicted_asset;
    logic [ID_W-1:0]   evicted_page;
    logic [ID_W-1:0]   slot_generation;
    logic              all_locked;
  } out_item_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic            vld;
    logic            free_hit;
    logic            lru_hit;
    logic [ID_W-1:0] best_frame;
    logic [ID_W-1:0] best_asset;
    logic [ID_W-1:0] best_page;
    logic [ID_W-1:0] best_gen;
  } scan_rec_t;

  // write-back broadcast to the row
  typedef struct packed {
    logic            en;
    logic            claim;
    logic            bump;
    logic            unlock;
    logic [ID_W-1:0] asset;
    logic [ID_W-1:0] page;
    logic [ID_W-1:0] frame;
  } wr_cmd_t;

endpackage

// ===== rtl/core/psa_cell.sv =====
// One slot cell: holds the slot state and updates the passing search record.
module psa_cell #(
  parameter int SLOT_ID = 0,
  parameter int IDX_W   = 8,
  parameter int CNT_W   = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        n_i,
  input  logic                    cmd_i,
  input  logic [psa_pkg::SLOT_W-1:0] target_i,
  input  psa_pkg::scan_rec_t      rec_i,
  input  logic [IDX_W-1:0]        idx_i,
  output psa_pkg::scan_rec_t      rec_o,
  output logic [IDX_W-1:0]        idx_o,
  input  psa_pkg::wr_cmd_t        wr_i,
  input  logic [IDX_W-1:0]        wr_idx_i
);

  logic                      alloc_r;
  logic                      lock_r;
  logic [psa_pkg::ID_W-1:0]  frame_r;
  logic [psa_pkg::ID_W-1:0]  asset_r;
  logic [psa_pkg::ID_W-1:0]  page_r;
  logic [psa_pkg::ID_W-1:0]  gen_r;

  psa_pkg::scan_rec_t rec_r, rec_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic active;
  logic wr_hit;

  assign active = CNT_W'(SLOT_ID) < n_i;
  assign wr_hit = wr_i.en && (wr_idx_i == IDX_W'(SLOT_ID));

  always_comb begin
    rec_nxt = rec_i;
    idx_nxt = idx_i;
    if (rec_i.vld && active) begin
      if (cmd_i == psa_pkg::CMD_UNLOCK) begin
        if (32'(SLOT_ID) == 32'(target_i)) begin
          rec_nxt.best_gen = gen_r;
        end
      end else if (!rec_i.free_hit) begin
        if (!alloc_r) begin
          // first free slot wins outright
          rec_nxt.free_hit = 1'b1;
          rec_nxt.best_gen = gen_r;
          idx_nxt          = IDX_W'(SLOT_ID);
        end else if (!lock_r && (!rec_i.lru_hit || frame_r < rec_i.best_frame)) begin
          // strict less keeps the lowest index on ties
          rec_nxt.lru_hit    = 1'b1;
          rec_nxt.best_frame = frame_r;
          rec_nxt.best_asset = asset_r;
          rec_nxt.best_page  = page_r;
          rec_nxt.best_gen   = gen_r;
          idx_nxt            = IDX_W'(SLOT_ID);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r   <= '0;
      idx_r   <= '0;
      alloc_r <= 1'b0;
      lock_r  <= 1'b0;
      gen_r   <= '0;
      frame_r <= '0;
      asset_r <= '0;
      page_r  <= '0;
    end else begin
      rec_r <= rec_nxt;
      idx_r <= idx_nxt;
      if (wr_hit) begin
        if (wr_i.claim) begin
          alloc_r <= 1'b1;
          lock_r  <= 1'b1;
          frame_r <= wr_i.frame;
          asset_r <= wr_i.asset;
          page_r  <= wr_i.page;
        end
        if (wr_i.unlock) begin
          lock_r <= 1'b0;
        end
        if (wr_i.bump) begin
          gen_r <= gen_r + 32'd1;
        end
      end
    end
  end

  assign rec_o = rec_r;
  assign idx_o = idx_r;

endmodule

// ===== rtl/core/page_slot_allocator_lru_locked_unit.sv =====
// Top level of the page slot allocator: command control and the row of slot cells.
//
// Page slot allocator with LRU replacement and locked (pinned) slots. A
// search record is launched into the head of a row of SLOT_COUNT cells and
// moves one cell per clock, each cell folding in its own slot (first free
// slot, else the unlocked slot with the oldest frame, lowest index on ties;
// for unlock, the target's generation). When the record leaves the last cell
// the controller forms the result and broadcasts the write-back, and the
// result item is shown on out_item for exactly one cycle with out_valid high.
// Busy drops at the end of the result cycle and the next item can be accepted
// in the cycle after it; no item is taken while one is in the row. The row
// length alone sets how long an item holds the block; no other stall exists.
// The receiver cannot stall: it must take the item in that cycle. start is
// taken only while busy is low; busy stays high from acceptance until the
// result cycle has ended. All slot state lives in flip-flops inside the cells
// and is cleared by reset, so no clearing pass is needed. cfg_slots (written
// through cfg_we/cfg_wdata while idle) limits the managed slots; values above
// SLOT_COUNT act as SLOT_COUNT, and zero makes every allocate report
// all_locked.
module page_slot_allocator_lru_locked_unit #(
  parameter int SLOT_COUNT = psa_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  psa_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output psa_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [psa_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  psa_pkg::in_item_t  item_r, item_nxt;
  psa_pkg::out_item_t out_item_r, out_item_nxt;
  psa_pkg::wr_cmd_t   wr_r, wr_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               head_vld_r, head_vld_nxt;
  logic [psa_pkg::CFG_W-1:0] cfg_slots_r;

  logic [CNT_W-1:0]   n_w;
  logic               tgt_ok;

  psa_pkg::scan_rec_t head_rec;
  psa_pkg::scan_rec_t rec_chain [SLOT_COUNT];
  logic [IDX_W-1:0]   idx_chain [SLOT_COUNT];
  psa_pkg::scan_rec_t tail_rec;
  logic [IDX_W-1:0]   tail_idx;

  // managed slot count, clamped to the row length
  always_comb begin
    if (32'(cfg_slots_r) > 32'(SLOT_COUNT)) begin
      n_w = CNT_W'(SLOT_COUNT);
    end else begin
      n_w = CNT_W'(cfg_slots_r);
    end
  end

  assign tgt_ok = 32'(item_r.target_slot) < 32'(n_w);

  always_comb begin
    head_rec     = '0;
    head_rec.vld = head_vld_r;
  end

  // row of slot cells
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      psa_cell #(
        .SLOT_ID (g),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_i      (n_w),
        .cmd_i    (item_r.command),
        .target_i (item_r.target_slot),
        .rec_i    (head_rec),
        .idx_i    ('0),
        .rec_o    (rec_chain[g]),
        .idx_o    (idx_chain[g]),
        .wr_i     (wr_r),
        .wr_idx_i (wr_idx_r)
      );
    end else begin : g_body
      psa_cell #(
        .SLOT_ID (g),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_i      (n_w),
        .cmd_i    (item_r.command),
        .target_i (item_r.target_slot),
        .rec_i    (rec_chain[g-1]),
        .idx_i    (idx_chain[g-1]),
        .rec_o    (rec_chain[g]),
        .idx_o    (idx_chain[g]),
        .wr_i     (wr_r),
        .wr_idx_i (wr_idx_r)
      );
    end
  end

  assign tail_rec = rec_chain[SLOT_COUNT-1];
  assign tail_idx = idx_chain[SLOT_COUNT-1];

  // command sequencing and result forming
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_item_nxt  = out_item_r;
    wr_nxt        = wr_r;
    wr_nxt.en     = 1'b0;
    wr_idx_nxt    = wr_idx_r;
    out_valid_nxt = 1'b0;
    head_vld_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt     = in_item;
          head_vld_nxt = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_rec.vld) begin
          out_item_nxt  = '0;
          out_valid_nxt = 1'b1;
          wr_nxt        = '0;
          wr_nxt.asset  = item_r.asset_id;
          wr_nxt.page   = item_r.page_id;
          wr_nxt.frame  = item_r.frame_number;
          wr_idx_nxt    = tail_idx;
          if (item_r.command == psa_pkg::CMD_UNLOCK) begin
            out_item_nxt.slot = item_r.target_slot;
            if (tgt_ok) begin
              out_item_nxt.slot_generation = tail_rec.best_gen;
              wr_nxt.en     = 1'b1;
              wr_nxt.unlock = 1'b1;
              wr_idx_nxt    = IDX_W'(item_r.target_slot);
            end
          end else if (tail_rec.free_hit) begin
            out_item_nxt.slot            = psa_pkg::SLOT_W'(tail_idx);
            out_item_nxt.slot_generation = tail_rec.best_gen;
            wr_nxt.en    = 1'b1;
            wr_nxt.claim = 1'b1;
          end else if (tail_rec.lru_hit) begin
            out_item_nxt.slot            = psa_pkg::SLOT_W'(tail_idx);
            out_item_nxt.evicted         = 1'b1;
            out_item_nxt.evicted_asset   = tail_rec.best_asset;
            out_item_nxt.evicted_page    = tail_rec.best_page;
            out_item_nxt.slot_generation = tail_rec.best_gen + 32'd1;
            wr_nxt.en    = 1'b1;
            wr_nxt.claim = 1'b1;
            wr_nxt.bump  = 1'b1;
          end else begin
            // every managed slot pinned: report slot 0, change nothing
            out_item_nxt.all_locked = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // cells take the write-back at the end of this cycle
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      head_vld_r  <= 1'b0;
      wr_r        <= '0;
      wr_idx_r    <= '0;
      item_r      <= '0;
      out_item_r  <= '0;
      cfg_slots_r <= psa_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_vld_r  <= head_vld_nxt;
      wr_r        <= wr_nxt;
      wr_idx_r    <= wr_idx_nxt;
      item_r      <= item_nxt;
      out_item_r  <= out_item_nxt;
      if (cfg_we) begin
        cfg_slots_r <= cfg_wdata;
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // accepted command always leaves idle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // only one record in flight: it exits the row only while scanning
  a_tail_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tail_rec.vld |-> (state_r == ST_SCAN))
    else $error("search record left the row outside a scan");

  // result appears in the cycle after the record leaves the row
  a_result_timing : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_DONE) && $past(tail_rec.vld))
    else $error("result strobe not tied to end of scan");

  // eviction and the all-locked fallback exclude each other
  a_result_flags : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.evicted && out_item_r.all_locked))
    else $error("evicted and all_locked both set");

  // generation bump only comes with a claim
  a_bump_claim : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r.en && wr_r.bump) |-> (wr_r.claim && out_valid_r && out_item_r.evicted))
    else $error("generation bump without an eviction claim");

endmodule

// ===== sim/page_slot_allocator_lru_locked_checker.sv =====
// Scoreboard for the page slot allocator: slot-state predictor and result compare.
`timescale 1ns / 100ps
module page_slot_allocator_lru_locked_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  psa_pkg::in_item_t         in_item,
  input  logic                      out_valid,
  input  psa_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [psa_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int NSLOT = psa_pkg::SLOT_COUNT_DEF;

  // shadow copy of the slot table
  bit          slot_used   [NSLOT];
  bit          slot_pinned [NSLOT];
  logic [31:0] used_frame  [NSLOT];
  logic [31:0] owner_asset [NSLOT];
  logic [31:0] owner_page  [NSLOT];
  logic [31:0] slot_gen    [NSLOT];
  logic [psa_pkg::CFG_W-1:0] slot_limit;

  psa_pkg::out_item_t placement_q[$];
  psa_pkg::out_item_t want;
  psa_pkg::out_item_t pred;
  int                 fail_count;

  function automatic void take_slot(int s, psa_pkg::in_item_t c);
    slot_used[s]   = 1'b1;
    slot_pinned[s] = 1'b1;
    owner_asset[s] = c.asset_id;
    owner_page[s]  = c.page_id;
    used_frame[s]  = c.frame_number;
  endfunction

  // Applies one command to the shadow table and returns the placement it reports.
  function automatic psa_pkg::out_item_t place_page(psa_pkg::in_item_t c);
    psa_pkg::out_item_t r;
    int          n;
    int          i;
    int          victim;
    logic [31:0] victim_frame;
    bit          found;
    r = '0;
    n = (slot_limit > NSLOT) ? NSLOT : int'(slot_limit);
    if (c.command == psa_pkg::CMD_UNLOCK) begin
      r.slot = c.target_slot;
      if (int'(c.target_slot) < n) begin
        slot_pinned[c.target_slot] = 1'b0;
        r.slot_generation = slot_gen[c.target_slot];
      end
      return r;
    end
    for (i = 0; i < n; i++) begin
      if (!slot_used[i]) begin
        take_slot(i, c);
        r.slot = i[psa_pkg::SLOT_W-1:0];
        r.slot_generation = slot_gen[i];
        return r;
      end
    end
    // no free slot: oldest unpinned frame, lowest index wins ties
    found = 1'b0;
    victim = 0;
    victim_frame = '0;
    for (i = 0; i < n; i++) begin
      if (!slot_pinned[i] && (!found || used_frame[i] < victim_frame)) begin
        found = 1'b1;
        victim = i;
        victim_frame = used_frame[i];
      end
    end
    if (!found) begin
      r.all_locked = 1'b1;
      return r;
    end
    r.evicted       = 1'b1;
    r.evicted_asset = owner_asset[victim];
    r.evicted_page  = owner_page[victim];
    take_slot(victim, c);
    slot_gen[victim] = slot_gen[victim] + 32'd1;
    r.slot = victim[psa_pkg::SLOT_W-1:0];
    r.slot_generation = slot_gen[victim];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_used[i]   = 1'b0;
        slot_pinned[i] = 1'b0;
        used_frame[i]  = '0;
        owner_asset[i] = '0;
        owner_page[i]  = '0;
        slot_gen[i]    = '0;
      end
      slot_limit = psa_pkg::CFG_RESET;
      placement_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) slot_limit = cfg_wdata;
      if (start && !busy) begin
        pred = place_page(in_item);
        placement_q = {placement_q, pred};
      end
      if (out_valid) begin
        if (placement_q.size() == 0) begin
          $error("result with no item outstanding: slot %0d", out_item.slot);
          fail_count++;
        end else begin
          want = placement_q.pop_front();
          check_field("slot", 32'(want.slot), 32'(out_item.slot));
          check_field("evicted", 32'(want.evicted), 32'(out_item.evicted));
          check_field("evicted_asset", want.evicted_asset, out_item.evicted_asset);
          check_field("evicted_page", want.evicted_page, out_item.evicted_page);
          check_field("slot_generation", want.slot_generation, out_item.slot_generation);
          check_field("all_locked", 32'(want.all_locked), 32'(out_item.all_locked));
        end
      end
    end
    // published after the edge so the stimulus side never races the update
    outstanding <= placement_q.size();
    mismatches  <= fail_count;
  end

endmodule

// ===== sim/page_slot_allocator_lru_locked_unit_tb.sv =====
// Testbench top for the page slot allocator: stimulus, phases of slot limits, verdict.
`timescale 1ns / 100ps
module page_slot_allocator_lru_locked_unit_tb;

  localparam int NSLOT  = psa_pkg::SLOT_COUNT_DEF;
  localparam int PHASES = 10;
  // settle at the end for longer than one item holds the block
  localparam int SETTLE = NSLOT + 44;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  psa_pkg::in_item_t         in_item;
  logic                      out_valid;
  psa_pkg::out_item_t        out_item;
  logic                      cfg_we;
  logic [psa_pkg::CFG_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;

  // burst mode: while set, the sender issues back to back
  bit          steady;
  // monotone frame counter, so LRU order mostly follows issue order
  logic [31:0] frame_clock;

  // Random phases: slot limit, item count, share of allocates (percent).
  // Small pools give eviction and all-locked traffic; the full pool needs
  // mostly allocates to fill up before it starts evicting.
  logic [psa_pkg::CFG_W-1:0] phase_limit [PHASES] =
    '{9'd5, 9'd1, 9'd8, 9'd256, 9'd3, 9'd300, 9'd0, 9'd16, 9'd2, 9'd511};
  int phase_items [PHASES] = '{120, 60, 150, 300, 100, 60, 20, 165, 100, 60};
  int phase_alloc [PHASES] = '{55, 50, 55, 90, 50, 90, 50, 55, 50, 60};

  always #1 clk = ~clk;

  page_slot_allocator_lru_locked_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  page_slot_allocator_lru_locked_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Mostly short gaps, a few long ones that can outlast a whole command.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(100, 400);
  endfunction

  function automatic psa_pkg::in_item_t alloc_cmd(logic [31:0] asset, logic [31:0] page,
                                                  logic [31:0] frame);
    psa_pkg::in_item_t c;
    c.command      = psa_pkg::CMD_ALLOC;
    c.asset_id     = asset;
    c.page_id      = page;
    c.frame_number = frame;
    c.target_slot  = psa_pkg::SLOT_W'($urandom);  // ignored on allocate
    return c;
  endfunction

  function automatic psa_pkg::in_item_t unlock_cmd(logic [psa_pkg::SLOT_W-1:0] s);
    psa_pkg::in_item_t c;
    c.command      = psa_pkg::CMD_UNLOCK;
    c.asset_id     = $urandom;  // the rest is ignored on unlock
    c.page_id      = $urandom;
    c.frame_number = $urandom;
    c.target_slot  = s;
    return c;
  endfunction

  // Presents one item after a random gap and returns in the step of the edge
  // that accepts it. start stays high so a zero-gap follower keeps it high
  // without a drop; any other caller lowers it in that same step.
  task automatic send_item(psa_pkg::in_item_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
  endtask

  // Stop issuing and wait for every outstanding result and for busy to drop.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // Slot limit is only changed with the block idle.
  task automatic set_slot_limit(logic [psa_pkg::CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    psa_pkg::in_item_t c;
    int       n;
    int       r;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    steady    = 1'b0;
    frame_clock = $urandom_range(0, 1000);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: two-slot pool ---
    set_slot_limit(9'd2);
    send_item(alloc_cmd(32'h0, 32'h0, 32'h0));                         // free slot 0
    send_item(alloc_cmd(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));    // free slot 1
    send_item(alloc_cmd(32'h12345678, 32'h9ABCDEF0, 32'h5));           // both pinned
    send_item(unlock_cmd(8'd255));                                     // outside pool
    send_item(unlock_cmd(8'd0));
    send_item(unlock_cmd(8'd0));                                       // already unlocked
    send_item(unlock_cmd(8'd1));
    send_item(alloc_cmd(32'hA5A5A5A5, 32'h5A5A5A5A, 32'h7));           // evicts frame 0
    send_item(alloc_cmd(32'hC3C3C3C3, 32'h3C3C3C3C, 32'h8));           // evicts top frame
    send_item(unlock_cmd(8'd0));
    send_item(unlock_cmd(8'd1));
    send_item(alloc_cmd(32'h11111111, 32'h22222222, 32'h8));           // slot 0 again
    send_item(unlock_cmd(8'd0));
    send_item(alloc_cmd(32'h33333333, 32'h44444444, 32'h9));           // frame tie
    send_item(unlock_cmd(8'd2));                                       // just past pool
    // empty pool: nothing can be placed, unlock is ignored
    set_slot_limit(9'd0);
    send_item(alloc_cmd(32'h55555555, 32'h66666666, 32'h10));
    send_item(unlock_cmd(8'd0));
    // oversized limit behaves as the full pool
    set_slot_limit(9'd511);
    send_item(alloc_cmd(32'h77777777, 32'h88888888, 32'h11));
    send_item(unlock_cmd(8'd255));                                     // never-used slot
    send_item(alloc_cmd(32'h99999999, 32'hAAAAAAAA, 32'h12));
    // single slot, pinned from above
    set_slot_limit(9'd1);
    send_item(alloc_cmd(32'hBBBBBBBB, 32'hCCCCCCCC, 32'h13));
    send_item(unlock_cmd(8'd0));
    send_item(alloc_cmd(32'hDDDDDDDD, 32'hEEEEEEEE, 32'h14));

    // --- random phases; slot table carries over from one phase to the next ---
    for (int p = 0; p < PHASES; p++) begin
      set_slot_limit(phase_limit[p]);
      n = (phase_limit[p] > NSLOT) ? NSLOT : int'(phase_limit[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        frame_clock += $urandom_range(0, 3);  // zero step makes ties
        c.asset_id    = $urandom;
        c.page_id     = $urandom;
        c.target_slot = psa_pkg::SLOT_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)       c.frame_number = $urandom;
        else if (r < 11) c.frame_number = 32'hFFFFFFFF;
        else             c.frame_number = frame_clock;
        if ($urandom_range(0, 99) < phase_alloc[p]) begin
          c.command = psa_pkg::CMD_ALLOC;
        end else begin
          c.command = psa_pkg::CMD_UNLOCK;
          // mostly real slots of the pool, the rest anywhere in the field
          if (n > 0 && $urandom_range(0, 99) < 80) begin
            c.target_slot = psa_pkg::SLOT_W'($urandom_range(0, n - 1));
          end
        end
        send_item(c);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/psa_pkg.sv
rtl/core/psa_cell.sv
rtl/core/page_slot_allocator_lru_locked_unit.sv
sim/page_slot_allocator_lru_locked_checker.sv
sim/page_slot_allocator_lru_locked_unit_tb.sv
